// File: hw/rtl/gefms_pkg.sv
// Shared types, constants and helpers of the earliest-free machine scheduler.
package gefms_pkg;

   localparam int MAX_MACHINES     = 8;
   localparam int DURATION_BITS    = 16;
   localparam int IDX_BITS         = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int LEAF_COUNT       = 1 << IDX_BITS;
   localparam int ACTIVE_BITS      = 4;
   localparam int IN_DURATION_BITS = 16;
   localparam int JOB_BITS         = 16;
   localparam int MACHINE_BITS     = 3;
   localparam int BUSY_BITS        = 24;
   localparam int SUM_BITS         =
      ((DURATION_BITS > BUSY_BITS) ? DURATION_BITS : BUSY_BITS) + 1;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = ACTIVE_BITS'(5);

   typedef enum logic {
      ACTION_SCHEDULE = 1'b0,
      ACTION_CLEAR    = 1'b1
   } action_type;

   typedef logic [DURATION_BITS-1:0] duration_type;
   typedef logic [IDX_BITS-1:0]      index_type;
   typedef logic [BUSY_BITS-1:0]     busy_type;
   typedef logic [JOB_BITS-1:0]      job_type;
   typedef logic [ACTIVE_BITS-1:0]   active_type;

   localparam busy_type BUSY_MAX = '1;

   typedef struct packed {
      logic         vld;
      index_type    idx;
      duration_type val;
   } cand_type;

   typedef struct packed {
      logic         fire;
      logic         clear;
      index_type    pick;
      duration_type least;
      duration_type duration;
   } upd_type;

   // Machine zero always takes part; others below the configured count.
   function automatic logic is_active(input int idx, input active_type count);
      return (idx == 0) || (idx < int'(count));
   endfunction

endpackage

// File: hw/rtl/gefms_argmin.sv
// Least-remaining-time search over the active machines, lowest index on a tie.
module gefms_argmin (
   input  gefms_pkg::active_type   active_count,
   input  gefms_pkg::duration_type remaining [gefms_pkg::MAX_MACHINES],
   output gefms_pkg::index_type    pick,
   output gefms_pkg::duration_type least
);
   import gefms_pkg::*;

   always_comb begin
      cand_type node [2*LEAF_COUNT];
      cand_type lt;
      cand_type rt;
      node[0] = '0;
      for (int i = 0; i < LEAF_COUNT; i++) begin
         if (i < MAX_MACHINES) begin
            node[LEAF_COUNT+i].vld = is_active(i, active_count);
            node[LEAF_COUNT+i].idx = IDX_BITS'(i);
            node[LEAF_COUNT+i].val = remaining[i];
         end else begin
            node[LEAF_COUNT+i] = '0;
         end
      end
      for (int k = LEAF_COUNT - 1; k >= 1; k--) begin
         lt = node[2*k];
         rt = node[2*k+1];
         if (lt.vld && (!rt.vld || lt.val <= rt.val)) begin
            node[k] = lt;
         end else begin
            node[k] = rt;
         end
      end
      pick  = node[1].idx;
      least = node[1].val;
   end

endmodule

// File: hw/rtl/gefms_bank.sv
// Per-machine remaining time and busy totals, job counter and their update.
module gefms_bank (
   input  logic                    clock,
   input  logic                    reset,
   input  gefms_pkg::active_type   active_count,
   input  gefms_pkg::upd_type      upd,
   output gefms_pkg::duration_type remaining [gefms_pkg::MAX_MACHINES],
   output gefms_pkg::busy_type     total_in,
   output gefms_pkg::job_type      job_in
);
   import gefms_pkg::*;

   duration_type            rem_ff  [MAX_MACHINES];
   busy_type                busy_ff [MAX_MACHINES];
   job_type                 job_ff;
   logic [SUM_BITS-1:0]     sum;

   assign remaining = rem_ff;
   assign sum       = SUM_BITS'(busy_ff[upd.pick]) + SUM_BITS'(upd.duration);
   assign total_in  = (sum > SUM_BITS'(BUSY_MAX)) ? BUSY_MAX : BUSY_BITS'(sum);
   assign job_in    = job_ff + JOB_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset || (upd.fire && upd.clear)) begin
         for (int i = 0; i < MAX_MACHINES; i++) begin
            rem_ff[i]  <= '0;
            busy_ff[i] <= '0;
         end
         job_ff <= '0;
      end else if (upd.fire) begin
         for (int i = 0; i < MAX_MACHINES; i++) begin
            if (is_active(i, active_count)) begin
               if (IDX_BITS'(i) == upd.pick) begin
                  rem_ff[i] <= upd.duration;
               end else begin
                  rem_ff[i] <= rem_ff[i] - upd.least;
               end
            end
         end
         busy_ff[upd.pick] <= total_in;
         job_ff            <= job_in;
      end
   end

endmodule

// File: hw/rtl/greedy_earliest_free_machine_scheduler.sv
// Top level of the greedy earliest-free machine scheduler.
//
// Each schedule item goes to the active machine with the least remaining time
// (lowest number on a tie); every active machine's remaining time drops by that
// minimum, the chosen one is loaded with the job's duration, and one result
// carries the machine, the job number since the last clear and the machine's
// saturating busy total. A clear item resets all counters and totals and gives
// no result. One item is accepted every clock while the result side keeps up;
// a schedule item waits in the input register while an unaccepted result holds
// the result register, and a clear item never waits. An accepted item sits in
// the input register, passes through the minimum search tree and state update,
// and a schedule item lands in the result register when it fires. The active
// machine count is to be written by the user through the csr port only while the
// block is idle, which the block itself does not enforce; zero counts as one machine.
module greedy_earliest_free_machine_scheduler (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic [gefms_pkg::IN_DURATION_BITS-1:0]  req_job_duration,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [gefms_pkg::MACHINE_BITS-1:0]      rsp_machine_number,
   output logic [gefms_pkg::JOB_BITS-1:0]          rsp_job_number,
   output logic [gefms_pkg::BUSY_BITS-1:0]         rsp_machine_busy_total,
   input  logic                                    csr_write_enable,
   input  logic [gefms_pkg::ACTIVE_BITS-1:0]       csr_write_data
);
   import gefms_pkg::*;

   active_type   active_ff;
   logic         in_valid_ff;
   action_type   in_action_ff;
   duration_type in_duration_ff;
   logic         out_valid_ff;
   logic [MACHINE_BITS-1:0] out_machine_ff;
   job_type      out_job_ff;
   busy_type     out_total_ff;

   logic         fire;
   logic         is_clear;
   index_type    pick;
   duration_type least;
   duration_type remaining [MAX_MACHINES];
   busy_type     total_in;
   job_type      job_in;
   upd_type      upd;

   assign is_clear  = (in_action_ff == ACTION_CLEAR);
   assign fire      = in_valid_ff && (is_clear || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   assign upd.fire     = fire;
   assign upd.clear    = is_clear;
   assign upd.pick     = pick;
   assign upd.least    = least;
   assign upd.duration = in_duration_ff;

   gefms_argmin u_argmin (
      .active_count (active_ff),
      .remaining    (remaining),
      .pick         (pick),
      .least        (least)
   );

   gefms_bank u_bank (
      .clock        (clock),
      .reset        (reset),
      .active_count (active_ff),
      .upd          (upd),
      .remaining    (remaining),
      .total_in     (total_in),
      .job_in       (job_in)
   );

   // hold config
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         in_action_ff   <= action_type'(req_action);
         in_duration_ff <= DURATION_BITS'(req_job_duration);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && !is_clear) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (fire && !is_clear) begin
         out_machine_ff <= MACHINE_BITS'(pick);
         out_job_ff     <= job_in;
         out_total_ff   <= total_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_machine_number     = out_machine_ff;
   assign rsp_job_number         = out_job_ff;
   assign rsp_machine_busy_total = out_total_ff;

endmodule

// File: tb/scheduler_checker.sv
// Checker for the earliest-free machine scheduler: tracks machine state and compares results.
`timescale 1ns / 1ps

module scheduler_checker
   import gefms_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_action,
   input  logic [IN_DURATION_BITS-1:0] req_job_duration,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [MACHINE_BITS-1:0]     rsp_machine_number,
   input  logic [JOB_BITS-1:0]         rsp_job_number,
   input  logic [BUSY_BITS-1:0]        rsp_machine_busy_total,
   input  logic                        csr_write_enable,
   input  logic [ACTIVE_BITS-1:0]      csr_write_data,
   output int                          fail_count,
   output int                          pending
);

   typedef struct packed {
      logic [MACHINE_BITS-1:0] machine;
      job_type                 job;
      busy_type                total;
   } assignment_type;

   duration_type   remain [MAX_MACHINES];
   busy_type       busy [MAX_MACHINES];
   job_type        jobs_done;
   active_type     active_reg;
   assignment_type assignment_q [$];
   assignment_type want;
   int             err_total = 0;
   int             pending_total = 0;

   assign fail_count = err_total;
   assign pending    = pending_total;

   task automatic report(input string msg);
      if (err_total < 40)
         $display("%0t ns checker: %s", $time, msg);
      err_total++;
   endtask

   function automatic void clear_machines();
      for (int i = 0; i < MAX_MACHINES; i++) begin
         remain[i] = '0;
         busy[i]   = '0;
      end
      jobs_done = '0;
   endfunction

   function automatic void place_job(input duration_type dur);
      int                  n;
      int                  pick;
      duration_type        least;
      logic [SUM_BITS-1:0] sum;
      assignment_type      rec;
      n = int'(active_reg);
      if (n == 0)
         n = 1;
      if (n > MAX_MACHINES)
         n = MAX_MACHINES;
      pick  = 0;
      least = remain[0];
      for (int i = 1; i < n; i++) begin
         if (remain[i] < least) begin
            least = remain[i];
            pick  = i;
         end
      end
      for (int i = 0; i < n; i++)
         remain[i] = remain[i] - least;
      remain[pick] = dur;
      sum = SUM_BITS'(busy[pick]) + SUM_BITS'(dur);
      if (sum > SUM_BITS'(BUSY_MAX))
         sum = SUM_BITS'(BUSY_MAX);
      busy[pick] = busy_type'(sum);
      jobs_done  = jobs_done + 1'b1;
      rec.machine = MACHINE_BITS'(pick);
      rec.job     = jobs_done;
      rec.total   = busy[pick];
      assignment_q.insert(assignment_q.size(), rec);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_machines();
         active_reg = ACTIVE_RESET;
         assignment_q.delete();
      end else begin
         if (csr_write_enable)
            active_reg = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (assignment_q.size() == 0) begin
               report($sformatf("result with no job waiting: machine %0d job %0d total %0d",
                                rsp_machine_number, rsp_job_number,
                                rsp_machine_busy_total));
            end else begin
               want = assignment_q.pop_front();
               if (rsp_machine_number !== want.machine)
                  report($sformatf("job %0d: machine %0d, expected %0d", want.job,
                                   rsp_machine_number, want.machine));
               if (rsp_job_number !== want.job)
                  report($sformatf("job number %0d, expected %0d", rsp_job_number,
                                   want.job));
               if (rsp_machine_busy_total !== want.total)
                  report($sformatf("job %0d: busy total %0d, expected %0d", want.job,
                                   rsp_machine_busy_total, want.total));
            end
         end
         if (req_valid && req_ready) begin
            if (action_type'(req_action) == ACTION_CLEAR)
               clear_machines();
            else
               place_job(duration_type'(req_job_duration));
         end
      end
      pending_total = assignment_q.size();
   end

endmodule

// File: tb/greedy_earliest_free_machine_scheduler_tb.sv
// Testbench top for the earliest-free machine scheduler: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module greedy_earliest_free_machine_scheduler_tb;
   import gefms_pkg::*;

   localparam int DIRECTED_COUNT = 24;
   localparam int PHASE_COUNT    = 11;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_action = 1'b0;
   logic [IN_DURATION_BITS-1:0] req_job_duration = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [MACHINE_BITS-1:0]     rsp_machine_number;
   logic [JOB_BITS-1:0]         rsp_job_number;
   logic [BUSY_BITS-1:0]        rsp_machine_busy_total;
   logic                        csr_write_enable = 1'b0;
   logic [ACTIVE_BITS-1:0]      csr_write_data = '0;
   int                          check_fails;
   int                          check_pending;
   int                          stall_left = 0;
   int                          calm_left = 0;

   action_type dir_act [DIRECTED_COUNT] = '{
      ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE,
      ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE,
      ACTION_CLEAR,    ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE,
      ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE,
      ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_CLEAR,    ACTION_CLEAR,
      ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE, ACTION_SCHEDULE
   };
   duration_type dir_dur [DIRECTED_COUNT] = '{
      16'd0,     16'hFFFF, 16'd1,     16'hFFFF, 16'd2,     16'd3,
      16'h8000,  16'h00FF, 16'hFFFF,  16'd7,     16'd7,     16'd7,
      16'd7,     16'd7,    16'd7,     16'hFFFF,  16'hFFFF,  16'd1,
      16'd0,     16'h1234, 16'h5555,  16'hAAAA,  16'd0,     16'd100
   };
   active_type phase_active [PHASE_COUNT] = '{
      4'd0, 4'd8, 4'd3, 4'd15, 4'd1, 4'd9, 4'd2, 4'd7, 4'd5, 4'd4, 4'd6
   };
   int phase_len [PHASE_COUNT] = '{75, 75, 75, 75, 300, 75, 75, 75, 75, 75, 75};
   bit phase_heavy [PHASE_COUNT] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};

   greedy_earliest_free_machine_scheduler dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_job_duration       (req_job_duration),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_machine_number     (rsp_machine_number),
      .rsp_job_number         (rsp_job_number),
      .rsp_machine_busy_total (rsp_machine_busy_total),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   scheduler_checker checker_inst (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_job_duration       (req_job_duration),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_machine_number     (rsp_machine_number),
      .rsp_job_number         (rsp_job_number),
      .rsp_machine_busy_total (rsp_machine_busy_total),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .fail_count             (check_fails),
      .pending                (check_pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic duration_type pick_duration(input bit heavy);
      int r;
      if (heavy)
         return duration_type'($urandom_range(60000, 65535));
      r = $urandom_range(0, 9);
      if (r < 2)
         return '0;
      if (r == 2)
         return '1;
      if (r < 6)
         return duration_type'($urandom_range(1, 15));
      return duration_type'($urandom_range(0, 65535));
   endfunction

   // stall the result side at random, with calm stretches of full throughput
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left <= calm_left - 1;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
         calm_left <= $urandom_range(30, 120);
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= gap_len();
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input action_type act, input duration_type dur, input int idle);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_job_duration <= dur;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // drain all results, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (check_pending != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_active(input active_type count);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      action_type act;
      bit         steady;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < DIRECTED_COUNT; k++)
         send_item(dir_act[k], dir_dur[k], gap_len());

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         write_active(phase_active[p]);
         steady = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < phase_len[p]; k++) begin
            if (!phase_heavy[p] && $urandom_range(0, 29) == 0)
               act = ACTION_CLEAR;
            else
               act = ACTION_SCHEDULE;
            send_item(act, pick_duration(phase_heavy[p]), steady ? 0 : gap_len());
         end
      end

      settle();
      if (check_fails == 0 && check_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/gefms_pkg.sv
hw/rtl/gefms_argmin.sv
hw/rtl/gefms_bank.sv
hw/rtl/greedy_earliest_free_machine_scheduler.sv
tb/scheduler_checker.sv
tb/greedy_earliest_free_machine_scheduler_tb.sv
